// File: rtl/core/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

  localparam int SAMPLE_BITS   = 13;
  localparam int FRACTION_BITS = 15;
  localparam int FW            = FRACTION_BITS + 1;
  localparam int TICK_BITS     = 16;
  localparam int BENCH_BITS    = 17;
  localparam int ALPHA_BITS    = 16;
  localparam int ALPHA_FRAC    = 15;
  localparam int STEP_BITS     = $clog2(FRACTION_BITS);

  localparam logic [FW-1:0]         FRAC_ONE   = FW'(1) << FRACTION_BITS;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE  = ALPHA_BITS'(1) << ALPHA_FRAC;
  localparam logic [ALPHA_BITS-1:0] ALPHA_INIT = ALPHA_BITS'(8192);
  localparam logic [ALPHA_FRAC:0]   EMA_HALF   = (ALPHA_FRAC+1)'(1) << (ALPHA_FRAC - 1);

  // Q.15 bench input rescaled to the fraction format
  localparam int BENCH_UP  = (FRACTION_BITS >= 15) ? FRACTION_BITS - 15 : 0;
  localparam int BENCH_DN  = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 0;
  localparam int BENCH_W   = BENCH_BITS + BENCH_UP;
  localparam logic [BENCH_BITS-1:0] BENCH_ONE = BENCH_BITS'(32768);

  // floor(d/20) = (d * RECIP) >> RECIP_SHIFT, exact for d < 2^18
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_BITS  = 16;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((2**RECIP_SHIFT + 19) / 20);

  localparam logic [SAMPLE_BITS-1:0] A_LOW_INIT  = SAMPLE_BITS'(1000);
  localparam logic [SAMPLE_BITS-1:0] A_HIGH_INIT = SAMPLE_BITS'(2100);
  localparam logic [SAMPLE_BITS-1:0] B_LOW_INIT  = SAMPLE_BITS'(3100);
  localparam logic [SAMPLE_BITS-1:0] B_HIGH_INIT = SAMPLE_BITS'(4000);

  localparam int ADDR_BITS = 3;
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BENCH = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_START  = 1'b1;

  typedef struct packed {
    logic seed;
    logic widen;
    logic shrink_calc;
    logic shrink_apply;
    logic div_load;
    logic div_step;
  } ppc_lane_cmd_t;

  typedef struct packed {
    logic sel;
    logic mul;
    logic fin;
  } ppc_merge_cmd_t;

  function automatic logic [FW-1:0] bench_clamp(input logic [BENCH_BITS-1:0] raw);
    logic [BENCH_W-1:0] v;
    v = '0;
    if (!raw[BENCH_BITS-1]) begin
      if (raw > BENCH_ONE) begin
        v = BENCH_W'(BENCH_ONE);
      end else begin
        v = BENCH_W'(raw);
      end
    end
    v = v << BENCH_UP;
    v = v >> BENCH_DN;
    return FW'(v);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ppc_in_if.sv
`default_nettype none
interface ppc_in_if;
  import ppc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [SAMPLE_BITS-1:0]        sensor_a_mv;
  logic [SAMPLE_BITS-1:0]        sensor_b_mv;
  logic signed [BENCH_BITS-1:0]  bench_travel;
  logic [TICK_BITS-1:0]          calibration_ticks;

  modport source (
    output valid, mode, sensor_a_mv, sensor_b_mv, bench_travel, calibration_ticks,
    input  ready
  );
  modport sink (
    input  valid, mode, sensor_a_mv, sensor_b_mv, bench_travel, calibration_ticks,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/ppc_out_if.sv
`default_nettype none
interface ppc_out_if;
  import ppc_pkg::*;

  logic          valid;
  logic          ready;
  logic [FW-1:0] travel_filtered;
  logic [FW-1:0] travel_unfiltered;
  logic [FW-1:0] fraction_a;
  logic [FW-1:0] fraction_b;
  logic          calibrating;
  logic          is_calibrated;

  modport source (
    output valid, travel_filtered, travel_unfiltered, fraction_a, fraction_b,
           calibrating, is_calibrated,
    input  ready
  );
  modport sink (
    input  valid, travel_filtered, travel_unfiltered, fraction_a, fraction_b,
           calibrating, is_calibrated,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/pedal_position_conditioner.sv
`default_nettype none
// channel   dir  handshake      payload
// sensors   in   valid/ready    mode, sensor_a_mv, sensor_b_mv, bench_travel,
//                               calibration_ticks
// travel    out  valid/ready    travel_filtered, travel_unfiltered, fraction_a,
//                               fraction_b, calibrating, is_calibrated
// apb       in   psel/penable   smoothing_alpha at 0x0, bench_mode at 0x4
//
// One item runs from accept to result through CAL, SHRINK (only when calibration
// closes; it applies the range shrink), LOAD, the 15-step restoring divider in
// each sensor lane, SEL, MUL, FIN and PUSH. One item is in work at a time.
// The result register lets the next item be accepted while a result waits.
// rst is synchronous; it restores the default ranges and registers.
module pedal_position_conditioner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ppc_in_if.sink                             sensors,
  ppc_out_if.source                          travel,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ppc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAL    = 4'd1;
  localparam logic [3:0] S_SHRINK = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SEL    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRACTION_BITS - 1);

  logic [3:0]              state;
  logic [3:0]              state_next;
  logic [STEP_BITS-1:0]    div_cnt;

  logic [ALPHA_BITS-1:0]   smoothing_alpha;
  logic                    bench_mode;

  logic                    it_mode;
  logic [SAMPLE_BITS-1:0]  it_sa;
  logic [SAMPLE_BITS-1:0]  it_sb;
  logic [BENCH_BITS-1:0]   it_bench;
  logic [TICK_BITS-1:0]    it_ticks;

  logic                    running;
  logic                    valid_cal;
  logic [TICK_BITS-1:0]    window_count;
  logic [TICK_BITS-1:0]    window_length;

  logic                    accept;
  logic                    cfg_write;
  logic                    out_free;
  logic                    closing;
  ppc_lane_cmd_t           lane_cmd;
  ppc_merge_cmd_t          merge_cmd;
  logic [FW-1:0]           lane_a_frac;
  logic [FW-1:0]           lane_b_frac;
  logic [FW-1:0]           m_filtered;
  logic [FW-1:0]           m_unfiltered;
  logic [FW-1:0]           m_frac_a;
  logic [FW-1:0]           m_frac_b;
  logic                    out_valid;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_alpha <= ALPHA_INIT;
      bench_mode      <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ALPHA: smoothing_alpha <= pwdata[ALPHA_BITS-1:0];
        REG_BENCH: bench_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ALPHA: prdata = {{(32-ALPHA_BITS){1'b0}}, smoothing_alpha};
      REG_BENCH: prdata = {31'b0, bench_mode};
      default:   prdata = '0;
    endcase
  end

  // sequencer
  assign sensors.ready = (state == S_IDLE);
  assign accept        = sensors.valid && sensors.ready;
  assign out_free      = !out_valid || travel.ready;
  assign closing       = (it_mode == MODE_SAMPLE) && running
                         && !(window_count < window_length);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_CAL;
      S_CAL:    state_next = closing ? S_SHRINK : S_LOAD;
      S_SHRINK: state_next = S_LOAD;
      S_LOAD:   state_next = S_DIV;
      S_DIV:    if (div_cnt == STEP_LAST) state_next = S_SEL;
      S_SEL:    state_next = S_MUL;
      S_MUL:    state_next = S_FIN;
      S_FIN:    state_next = S_PUSH;
      S_PUSH:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_mode  <= sensors.mode;
      it_sa    <= sensors.sensor_a_mv;
      it_sb    <= sensors.sensor_b_mv;
      it_bench <= sensors.bench_travel;
      it_ticks <= sensors.calibration_ticks;
    end
  end

  // calibration window
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      valid_cal     <= 1'b1;
      window_count  <= '0;
      window_length <= '0;
    end else if (state == S_CAL) begin
      if (it_mode == MODE_START) begin
        if (!running) begin
          running       <= 1'b1;
          valid_cal     <= 1'b0;
          window_length <= it_ticks;
        end
        window_count <= '0;
      end else if (running) begin
        if (window_count < window_length) begin
          window_count <= window_count + 1'b1;
        end else begin
          running   <= 1'b0;
          valid_cal <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    lane_cmd              = '0;
    lane_cmd.seed         = (state == S_CAL) && (it_mode == MODE_START) && !running;
    lane_cmd.widen        = (state == S_CAL) && (it_mode == MODE_SAMPLE) && running
                            && (window_count < window_length);
    lane_cmd.shrink_calc  = (state == S_CAL) && closing;
    lane_cmd.shrink_apply = (state == S_SHRINK);
    lane_cmd.div_load     = (state == S_LOAD);
    lane_cmd.div_step     = (state == S_DIV);
    merge_cmd             = '0;
    merge_cmd.sel         = (state == S_SEL);
    merge_cmd.mul         = (state == S_MUL);
    merge_cmd.fin         = (state == S_FIN);
  end

  ppc_lane u_lane_a (
    .clk        (clk),
    .rst        (rst),
    .cmd        (lane_cmd),
    .sample     (it_sa),
    .reset_low  (A_LOW_INIT),
    .reset_high (A_HIGH_INIT),
    .fraction   (lane_a_frac)
  );

  ppc_lane u_lane_b (
    .clk        (clk),
    .rst        (rst),
    .cmd        (lane_cmd),
    .sample     (it_sb),
    .reset_low  (B_LOW_INIT),
    .reset_high (B_HIGH_INIT),
    .fraction   (lane_b_frac)
  );

  ppc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .cmd        (merge_cmd),
    .lane_a     (lane_a_frac),
    .lane_b     (lane_b_frac),
    .bench_frac (bench_clamp(it_bench)),
    .bench_mode (bench_mode),
    .blank      (running || !valid_cal),
    .alpha      (smoothing_alpha),
    .filtered   (m_filtered),
    .unfiltered (m_unfiltered),
    .frac_a     (m_frac_a),
    .frac_b     (m_frac_b)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (travel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      travel.travel_filtered   <= m_filtered;
      travel.travel_unfiltered <= m_unfiltered;
      travel.fraction_a        <= m_frac_a;
      travel.fraction_b        <= m_frac_b;
      travel.calibrating       <= running;
      travel.is_calibrated     <= valid_cal;
    end
  end

  assign travel.valid = out_valid;
endmodule
`default_nettype wire

// File: rtl/core/ppc_lane.sv
`default_nettype none
module ppc_lane (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ppc_pkg::ppc_lane_cmd_t          cmd,
  input  wire logic [ppc_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [ppc_pkg::SAMPLE_BITS-1:0] reset_low,
  input  wire logic [ppc_pkg::SAMPLE_BITS-1:0] reset_high,
  output logic [ppc_pkg::FW-1:0]               fraction
);
  import ppc_pkg::*;

  logic [SAMPLE_BITS-1:0]             low;
  logic [SAMPLE_BITS-1:0]             high;
  logic [SAMPLE_BITS-1:0]             step;
  logic [SAMPLE_BITS-1:0]             rem;
  logic [SAMPLE_BITS-1:0]             dvs;
  logic [FRACTION_BITS-1:0]           quo;
  logic                               zero;
  logic                               sat;
  logic [SAMPLE_BITS-1:0]             span;
  logic [SAMPLE_BITS+RECIP_BITS-1:0]  prod;
  logic [SAMPLE_BITS:0]               rem2;
  logic                               fits;

  assign span = (high > low) ? high - low : '0;
  assign prod = (SAMPLE_BITS+RECIP_BITS)'(span) * (SAMPLE_BITS+RECIP_BITS)'(RECIP);
  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= reset_low;
      high <= reset_high;
    end else if (cmd.seed) begin
      low  <= sample;
      high <= sample;
    end else if (cmd.widen) begin
      if (sample < low) begin
        low <= sample;
      end
      if (sample > high) begin
        high <= sample;
      end
    end else if (cmd.shrink_apply) begin
      low  <= low + step;
      high <= high - step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shrink_calc) begin
      step <= SAMPLE_BITS'(prod >> RECIP_SHIFT);
    end
    if (cmd.div_load) begin
      quo  <= '0;
      dvs  <= high - low;
      zero <= (high <= low) || (sample <= low);
      sat  <= sample >= high;
      rem  <= (high > low && sample > low && sample < high) ? sample - low : '0;
    end else if (cmd.div_step) begin
      quo <= {quo[FRACTION_BITS-2:0], fits};
      rem <= fits ? SAMPLE_BITS'(rem2 - {1'b0, dvs}) : SAMPLE_BITS'(rem2);
    end
  end

  always_comb begin
    if (zero) begin
      fraction = '0;
    end else if (sat) begin
      fraction = FRAC_ONE;
    end else begin
      fraction = {1'b0, quo};
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/ppc_merge.sv
`default_nettype none
module ppc_merge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ppc_pkg::ppc_merge_cmd_t        cmd,
  input  wire logic [ppc_pkg::FW-1:0]         lane_a,
  input  wire logic [ppc_pkg::FW-1:0]         lane_b,
  input  wire logic [ppc_pkg::FW-1:0]         bench_frac,
  input  wire logic                           bench_mode,
  input  wire logic                           blank,
  input  wire logic [ppc_pkg::ALPHA_BITS-1:0] alpha,
  output logic [ppc_pkg::FW-1:0]              filtered,
  output logic [ppc_pkg::FW-1:0]              unfiltered,
  output logic [ppc_pkg::FW-1:0]              frac_a,
  output logic [ppc_pkg::FW-1:0]              frac_b
);
  import ppc_pkg::*;

  localparam int PW = ALPHA_BITS + FW;

  logic [FW-1:0]         x;
  logic                  clear;
  logic [PW-1:0]         p_new;
  logic [PW-1:0]         p_old;
  logic [FW:0]           sum_ab;
  logic [ALPHA_BITS-1:0] a_eff;
  logic [PW:0]           acc;

  assign sum_ab = {1'b0, lane_a} + {1'b0, lane_b};
  assign a_eff  = (alpha == '0 || alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign acc    = {1'b0, p_new} + {1'b0, p_old} + (PW+1)'(EMA_HALF);

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      if (bench_mode) begin
        x      <= bench_frac;
        frac_a <= bench_frac;
        frac_b <= bench_frac;
        clear  <= 1'b0;
      end else if (blank) begin
        x      <= '0;
        frac_a <= '0;
        frac_b <= '0;
        clear  <= 1'b1;
      end else begin
        x      <= sum_ab[FW:1];
        frac_a <= lane_a;
        frac_b <= lane_b;
        clear  <= 1'b0;
      end
    end
    if (cmd.mul) begin
      p_new <= PW'(a_eff) * PW'(x);
      p_old <= PW'(ALPHA_ONE - a_eff) * PW'(filtered);
    end
  end

  assign unfiltered = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered <= '0;
    end else if (cmd.fin) begin
      filtered <= clear ? '0 : acc[ALPHA_FRAC +: FW];
    end
  end
endmodule
`default_nettype wire

// File: dv/pedal_position_conditioner_tb.sv
`default_nettype none
module pedal_position_conditioner_tb;
  import ppc_pkg::*;

  localparam int LIMIT = 600000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 215;
  localparam int HOLD_CYCLES = 600;
  localparam logic [ADDR_BITS-1:0] ALPHA_ADDR = ADDR_BITS'(4 * REG_ALPHA);
  localparam logic [ADDR_BITS-1:0] BENCH_ADDR = ADDR_BITS'(4 * REG_BENCH);

  typedef struct packed {
    logic                          mode;
    logic [SAMPLE_BITS-1:0]        a_mv;
    logic [SAMPLE_BITS-1:0]        b_mv;
    logic signed [BENCH_BITS-1:0]  bench;
    logic [TICK_BITS-1:0]          ticks;
  } sensor_item_t;

  typedef struct packed {
    logic [FW-1:0] filtered;
    logic [FW-1:0] unfiltered;
    logic [FW-1:0] frac_a;
    logic [FW-1:0] frac_b;
    logic          calibrating;
    logic          calibrated;
  } travel_item_t;

  class travel_tracker;
    logic [SAMPLE_BITS-1:0] a_lo, a_hi, b_lo, b_hi;
    bit                     running, cal_ok;
    logic [TICK_BITS-1:0]   win_cnt, win_len;
    logic [FW-1:0]          smooth;
    logic [ALPHA_BITS-1:0]  alpha;
    bit                     bench;
    travel_item_t           pending_travel[$];
    int                     errors;
    int                     results_seen;

    function new();
      a_lo = A_LOW_INIT;
      a_hi = A_HIGH_INIT;
      b_lo = B_LOW_INIT;
      b_hi = B_HIGH_INIT;
      running = 0;
      cal_ok = 1;
      win_cnt = '0;
      win_len = '0;
      smooth = '0;
      alpha = ALPHA_INIT;
      bench = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endfunction

    function logic [FW-1:0] lane_fraction(logic [SAMPLE_BITS-1:0] v, lo, hi);
      int unsigned d, span;
      if (hi <= lo || v <= lo) return '0;
      if (v >= hi) return FRAC_ONE;
      d = v - lo;
      span = hi - lo;
      return FW'((d << FRACTION_BITS) / span);
    endfunction

    function void narrow(inout logic [SAMPLE_BITS-1:0] lo, hi);
      int unsigned s;
      s = (hi > lo) ? (hi - lo) / 20 : 0;
      lo = lo + SAMPLE_BITS'(s);
      hi = hi - SAMPLE_BITS'(s);
    endfunction

    function void blend(logic [FW-1:0] x);
      longint unsigned a, acc;
      a = alpha;
      if (a == 0 || a > ALPHA_ONE) a = ALPHA_ONE;
      acc = a * x + (ALPHA_ONE - a) * smooth + EMA_HALF;
      smooth = FW'(acc >> ALPHA_FRAC);
    endfunction

    function logic [FW-1:0] clamp_bench(logic signed [BENCH_BITS-1:0] raw);
      int v;
      v = raw;
      if (v < 0) return '0;
      if (v > 32768) v = 32768;
      return FW'(v << BENCH_UP);
    endfunction

    function void accept_sample(sensor_item_t it);
      travel_item_t r;
      logic [FW:0] sum;
      if (it.mode == MODE_START) begin
        if (!running) begin
          running = 1;
          cal_ok = 0;
          a_lo = it.a_mv;
          a_hi = it.a_mv;
          b_lo = it.b_mv;
          b_hi = it.b_mv;
          win_len = it.ticks;
        end
        win_cnt = '0;
      end else if (running) begin
        if (win_cnt < win_len) begin
          if (it.a_mv < a_lo) a_lo = it.a_mv;
          if (it.a_mv > a_hi) a_hi = it.a_mv;
          if (it.b_mv < b_lo) b_lo = it.b_mv;
          if (it.b_mv > b_hi) b_hi = it.b_mv;
          win_cnt = win_cnt + 1'b1;
        end else begin
          narrow(a_lo, a_hi);
          narrow(b_lo, b_hi);
          running = 0;
          cal_ok = 1;
        end
      end
      if (bench) begin
        r.unfiltered = clamp_bench(it.bench);
        r.frac_a = r.unfiltered;
        r.frac_b = r.unfiltered;
        blend(r.unfiltered);
      end else if (running || !cal_ok) begin
        r.unfiltered = '0;
        r.frac_a = '0;
        r.frac_b = '0;
        smooth = '0;
      end else begin
        r.frac_a = lane_fraction(it.a_mv, a_lo, a_hi);
        r.frac_b = lane_fraction(it.b_mv, b_lo, b_hi);
        sum = {1'b0, r.frac_a} + r.frac_b;
        r.unfiltered = FW'(sum >> 1);
        blend(r.unfiltered);
      end
      r.filtered = smooth;
      r.calibrating = running;
      r.calibrated = cal_ok;
      pending_travel.push_back(r);
    endfunction

    function void cmp(string what, logic [FW-1:0] got, logic [FW-1:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", what, got, want));
    endfunction

    function void check_travel(travel_item_t got);
      travel_item_t want;
      results_seen++;
      if (pending_travel.size() == 0) begin
        report("travel item with none expected");
        return;
      end
      want = pending_travel.pop_front();
      cmp("travel_filtered", got.filtered, want.filtered);
      cmp("travel_unfiltered", got.unfiltered, want.unfiltered);
      cmp("fraction_a", got.frac_a, want.frac_a);
      cmp("fraction_b", got.frac_b, want.frac_b);
      cmp("calibrating", FW'(got.calibrating), FW'(want.calibrating));
      cmp("is_calibrated", FW'(got.calibrated), FW'(want.calibrated));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ppc_in_if  sensors_if ();
  ppc_out_if travel_if ();

  pedal_position_conditioner u_top (
    .clk     (clk),
    .rst     (rst),
    .sensors (sensors_if),
    .travel  (travel_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  travel_tracker tracker = new();

  int  cycles = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  int  settings_used = 0;
  bit  hold_done = 0;
  int  hold_left = 0;
  int  stall_cycle = 0;
  int  stall_style = 0;

  int  alpha_set[PHASES] = '{8192, 32768, 0, 1, 65535, 16384, -1};
  bit  bench_set[PHASES] = '{0, 0, 1, 0, 0, 1, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycles,
               tracker.pending_travel.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: own stall pattern plus one long hold
  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_style = $urandom_range(0, 3);
    if (!hold_done && settings_used == 2) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      travel_if.ready <= 1'b0;
    end else begin
      case (stall_style)
        0: travel_if.ready <= 1'b1;
        1: travel_if.ready <= ($urandom_range(0, 3) != 0);
        2: travel_if.ready <= ($urandom_range(0, 3) == 0);
        default: travel_if.ready <= stall_cycle[0];
      endcase
    end
  end

  always @(posedge clk) begin : watch
    sensor_item_t s;
    travel_item_t t;
    if (!rst) begin
      if (sensors_if.valid && sensors_if.ready) begin
        s.mode = sensors_if.mode;
        s.a_mv = sensors_if.sensor_a_mv;
        s.b_mv = sensors_if.sensor_b_mv;
        s.bench = sensors_if.bench_travel;
        s.ticks = sensors_if.calibration_ticks;
        tracker.accept_sample(s);
      end
      if (travel_if.valid && travel_if.ready) begin
        t.filtered = travel_if.travel_filtered;
        t.unfiltered = travel_if.travel_unfiltered;
        t.frac_a = travel_if.fraction_a;
        t.frac_b = travel_if.fraction_b;
        t.calibrating = travel_if.calibrating;
        t.calibrated = travel_if.is_calibrated;
        tracker.check_travel(t);
      end
    end
  end

  task automatic send_item(input logic mode, input int a_mv, input int b_mv,
                           input int bench, input int ticks);
    if (burst_left == 0) begin
      sensors_if.valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    sensors_if.valid <= 1'b1;
    sensors_if.mode <= mode;
    sensors_if.sensor_a_mv <= SAMPLE_BITS'(a_mv);
    sensors_if.sensor_b_mv <= SAMPLE_BITS'(b_mv);
    sensors_if.bench_travel <= BENCH_BITS'(bench);
    sensors_if.calibration_ticks <= TICK_BITS'(ticks);
    do @(posedge clk); while (!(sensors_if.valid && sensors_if.ready));
    items_sent++;
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input int unsigned data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    sensors_if.valid <= 1'b0;
    while (tracker.pending_travel.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int rand_mv();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 5000;
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic int rand_bench();
    case ($urandom_range(0, 7))
      0, 1: return -int'($urandom_range(1, 65536));
      2: return $urandom_range(32769, 65535);
      3: return 32768;
      4: return 0;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic sample_run(input int n);
    repeat (n) send_item(MODE_SAMPLE, rand_mv(), rand_mv(), rand_bench(),
                         $urandom_range(0, 65535));
  endtask

  // start, widen for len ticks (optionally extended once), close, then track
  task automatic calib_window();
    int len, ext_at, total, i;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 150) : $urandom_range(0, 12);
    ext_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : -1;
    total = len + 1 + ((ext_at > 0) ? ext_at : 0);
    send_item(MODE_START, rand_mv(), rand_mv(), rand_bench(), len);
    for (i = 0; i < total; i++) begin
      if (i == ext_at) send_item(MODE_START, rand_mv(), rand_mv(), rand_bench(),
                                 $urandom_range(0, 65535));
      sample_run(1);
    end
    sample_run($urandom_range(5, 30));
  endtask

  task automatic noise_run();
    repeat ($urandom_range(1, 6)) begin
      send_item(($urandom_range(0, 5) == 0) ? MODE_START : MODE_SAMPLE,
                $urandom_range(0, 5000), $urandom_range(0, 5000), rand_bench(),
                $urandom_range(0, 20));
    end
  endtask

  task automatic random_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) != 0) calib_window();
      else noise_run();
    end
  endtask

  task automatic sensor_directed();
    send_item(MODE_SAMPLE, 0, 0, 0, 0);
    send_item(MODE_SAMPLE, 5000, 5000, 0, 0);
    send_item(MODE_SAMPLE, 1000, 3100, 0, 0);
    send_item(MODE_SAMPLE, 2100, 4000, 0, 0);
    send_item(MODE_SAMPLE, 1550, 3550, 0, 0);
    send_item(MODE_SAMPLE, 1001, 3999, 0, 0);
    // zero-length window over an empty range
    send_item(MODE_START, 2000, 2000, 0, 0);
    send_item(MODE_SAMPLE, 4000, 100, 0, 0);
    // window extended while running, then widened and closed
    send_item(MODE_START, 1500, 3000, 0, 3);
    send_item(MODE_START, 1200, 2900, -1, 65535);
    send_item(MODE_SAMPLE, 800, 4200, 0, 0);
    send_item(MODE_SAMPLE, 2500, 2600, 0, 0);
    send_item(MODE_SAMPLE, 100, 4900, 0, 0);
    send_item(MODE_SAMPLE, 2000, 3000, 0, 0);
    send_item(MODE_SAMPLE, 2380, 2600, 0, 0);
    send_item(MODE_SAMPLE, 0, 5000, 0, 0);
    send_item(MODE_SAMPLE, 8191, 8191, 0, 0);
  endtask

  task automatic bench_directed();
    send_item(MODE_SAMPLE, 0, 0, -65536, 0);
    send_item(MODE_SAMPLE, 0, 0, -1, 0);
    send_item(MODE_SAMPLE, 0, 0, 0, 0);
    send_item(MODE_SAMPLE, 0, 0, 16384, 0);
    send_item(MODE_SAMPLE, 0, 0, 32767, 0);
    send_item(MODE_SAMPLE, 0, 0, 32768, 0);
    send_item(MODE_SAMPLE, 0, 0, 32769, 0);
    send_item(MODE_SAMPLE, 0, 0, 65535, 0);
    send_item(MODE_START, 3000, 1000, 20000, 2);
  endtask

  initial begin : main_seq
    int p, alpha;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sensors_if.valid = 1'b0;
    sensors_if.mode = MODE_SAMPLE;
    sensors_if.sensor_a_mv = '0;
    sensors_if.sensor_b_mv = '0;
    sensors_if.bench_travel = '0;
    sensors_if.calibration_ticks = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        alpha = (alpha_set[p] < 0) ? $urandom_range(2, 32767) : alpha_set[p];
        apb_write(ALPHA_ADDR, alpha);
        apb_write(BENCH_ADDR, bench_set[p]);
        tracker.alpha = ALPHA_BITS'(alpha);
        tracker.bench = bench_set[p];
      end
      settings_used++;
      if (p == 0) sensor_directed();
      if (p == 2) bench_directed();
      random_phase(PHASE_ITEMS);
    end
    settle();
    $display("sent %0d items over %0d register settings, %0d results checked",
             items_sent, settings_used, tracker.results_seen);
    $display("covered sensor and bench paths, window start/extend/close, alpha extremes");
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
